// ===== hdl/preemptive_priority_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// Checked outside reset only.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;
  } in_word_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic [15:0] burst_left;
    logic        task_done;
  } out_word_t;

  // slot table write command
  typedef struct packed {
    logic load;
    logic update;
    logic set_done;
  } tbl_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

endpackage

// ===== hdl/pps_slot_table.sv =====
// ----------------------------------------------------------------------------
// pps_slot_table
// Task slot storage: arrival, priority and remaining burst memories with one
// registered read port, plus per-slot valid and done flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_slot_table #(
  parameter int NUM_SLOTS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pps_pkg::tbl_cmd_t            cmd_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr_i,
  input  logic [15:0]                  wr_arrival_i,
  input  logic [PRIORITY_BITS-1:0]     wr_prio_i,
  input  logic [15:0]                  wr_remaining_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr_i,
  output logic [15:0]                  rd_arrival_o,
  output logic [PRIORITY_BITS-1:0]     rd_prio_o,
  output logic [15:0]                  rd_remaining_o,
  output logic                         rd_elig_o
);

  logic [15:0]              arrival_mem   [NUM_SLOTS];
  logic [PRIORITY_BITS-1:0] prio_mem      [NUM_SLOTS];
  logic [15:0]              remaining_mem [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] valid_q;
  logic [NUM_SLOTS-1:0] done_q;
  logic                 elig_q;

  logic [15:0]              rd_arrival_q;
  logic [PRIORITY_BITS-1:0] rd_prio_q;
  logic [15:0]              rd_remaining_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arrival_mem[wr_addr_i] <= wr_arrival_i;
      prio_mem[wr_addr_i]    <= wr_prio_i;
    end
    if (cmd_i.load || cmd_i.update) begin
      remaining_mem[wr_addr_i] <= wr_remaining_i;
    end
    rd_arrival_q   <= arrival_mem[rd_addr_i];
    rd_prio_q      <= prio_mem[rd_addr_i];
    rd_remaining_q <= remaining_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= '0;
      elig_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        valid_q[wr_addr_i] <= 1'b1;
        done_q[wr_addr_i]  <= (wr_remaining_i == 16'd0);
      end else if (cmd_i.update && cmd_i.set_done) begin
        done_q[wr_addr_i] <= 1'b1;
      end
      elig_q <= valid_q[rd_addr_i] & ~done_q[rd_addr_i];
    end
  end

  assign rd_arrival_o   = rd_arrival_q;
  assign rd_prio_o      = rd_prio_q;
  assign rd_remaining_o = rd_remaining_q;
  assign rd_elig_o      = elig_q;

endmodule

// ===== hdl/preemptive_priority_scheduler_top.sv =====
// Load word: the result word passes through the EMIT state into the output register.
// Tick word: the result follows a scan that reads one slot per cycle through the
// table's single read port and a shared compare, then the UPDATE and EMIT states.
// One word in flight: the next word is taken only once the result has moved into
// the output register, which waits while the output is stalled.
// Reset clears time, all slot valid/done flags and the output valid.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Task slot table with a sequential lowest-priority-number search per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_top_macros.svh"

module preemptive_priority_scheduler_top #(
  parameter int NUM_SLOTS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pps_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pps_pkg::out_word_t out_word_o
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W:0] SCAN_END = (SLOT_W + 1)'(NUM_SLOTS);

  pps_pkg::state_e    state_q, state_d;
  logic [SLOT_W:0]    scan_cnt_q, scan_cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]  rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  best_slot_q, best_slot_d;
  logic [PRIORITY_BITS-1:0] best_prio_q, best_prio_d;
  logic [15:0]        best_rem_q, best_rem_d;
  logic [15:0]        sched_time_q, sched_time_d;
  pps_pkg::out_word_t res_q, res_d;
  pps_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic                     in_fire;
  logic                     load_ok;
  logic                     issue;
  logic                     hit;
  logic                     emit_fire;
  logic [15:0]              left;
  pps_pkg::tbl_cmd_t        cmd;
  logic [SLOT_W-1:0]        wr_addr;
  logic [15:0]              wr_rem;
  logic [SLOT_W-1:0]        rd_addr;
  logic [15:0]              rd_arrival;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [15:0]              rd_remaining;
  logic                     rd_elig;
  logic                     tick_fire;
  logic                     scan_st;
  logic                     upd_st;
  logic                     time_step;

  assign in_stall_o = (state_q != pps_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign load_ok    = (32'(in_word_i.slot) < NUM_SLOTS);
  assign issue      = (state_q == pps_pkg::ST_SCAN) && (scan_cnt_q < SCAN_END);
  assign rd_addr    = scan_cnt_q[SLOT_W-1:0];

  // strict less-than keeps the lowest slot on equal priority
  assign hit = rd_vld_q && rd_elig && (rd_arrival <= sched_time_q) &&
               (!found_q || (rd_prio < best_prio_q));

  assign left      = best_rem_q - {15'd0, (best_rem_q != 16'd0)};
  assign emit_fire = (state_q == pps_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign tick_fire = in_fire && (in_word_i.req_type == pps_pkg::REQ_TICK);
  assign scan_st   = (state_q == pps_pkg::ST_SCAN);
  assign upd_st    = (state_q == pps_pkg::ST_UPDATE);
  assign time_step = upd_st && (sched_time_d == sched_time_q + 16'd1);

  always_comb begin
    cmd.load     = in_fire && (in_word_i.req_type == pps_pkg::REQ_LOAD) && load_ok;
    cmd.update   = (state_q == pps_pkg::ST_UPDATE) && found_q;
    cmd.set_done = (left == 16'd0);
    if (state_q == pps_pkg::ST_UPDATE) begin
      wr_addr = best_slot_q;
      wr_rem  = left;
    end else begin
      wr_addr = SLOT_W'(in_word_i.slot);
      wr_rem  = in_word_i.burst_length;
    end
  end

  pps_slot_table #(
    .NUM_SLOTS     (NUM_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .wr_addr_i      (wr_addr),
    .wr_arrival_i   (in_word_i.arrival_time),
    .wr_prio_i      (PRIORITY_BITS'(in_word_i.task_priority)),
    .wr_remaining_i (wr_rem),
    .rd_addr_i      (rd_addr),
    .rd_arrival_o   (rd_arrival),
    .rd_prio_o      (rd_prio),
    .rd_remaining_o (rd_remaining),
    .rd_elig_o      (rd_elig)
  );

  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_prio_d  = best_prio_q;
    best_rem_d   = best_rem_q;
    sched_time_d = sched_time_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_word_i.req_type == pps_pkg::REQ_TICK) begin
            scan_cnt_d = '0;
            found_d    = 1'b0;
            state_d    = pps_pkg::ST_SCAN;
          end else begin
            res_d   = '0;
            state_d = pps_pkg::ST_EMIT;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        if (issue) begin
          rd_vld_d   = 1'b1;
          rd_idx_d   = rd_addr;
          scan_cnt_d = scan_cnt_q + (SLOT_W + 1)'(1);
        end else begin
          // last compare lands this cycle
          state_d = pps_pkg::ST_UPDATE;
        end
        if (hit) begin
          found_d     = 1'b1;
          best_slot_d = rd_idx_q;
          best_prio_d = rd_prio;
          best_rem_d  = rd_remaining;
        end
      end
      pps_pkg::ST_UPDATE: begin
        res_d           = '0;
        res_d.tick_time = sched_time_q;
        if (found_q) begin
          res_d.running_valid = 1'b1;
          res_d.running_slot  = 4'(best_slot_q);
          res_d.burst_left    = left;
          res_d.task_done     = (left == 16'd0);
        end
        if (sched_time_q != pps_pkg::TIME_MAX) begin
          sched_time_d = sched_time_q + 16'd1;
        end
        state_d = pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pps_pkg::ST_IDLE;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      sched_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_cnt_q   <= scan_cnt_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      sched_time_q <= sched_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_slot_q <= best_slot_d;
    best_prio_q <= best_prio_d;
    best_rem_q  <= best_rem_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `PPS_ASSERT(a_tick_scan, tick_fire |=> scan_st && (scan_cnt_q == '0), "tick not scanned")
  `PPS_ASSERT(a_full_scan, upd_st |-> (scan_cnt_q == SCAN_END) && !rd_vld_q, "early update")
  `PPS_ASSERT(a_time_step, !$stable(sched_time_q) |-> $past(time_step), "time moved off a tick")

endmodule
